/* rtl/buddy_block_allocator_unit_defines.svh */
// Assertion macros used by the checker file.
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bba_pkg.sv */
package bba_pkg;

    localparam int TREE_LEVELS = 12;
    localparam int NODE_W      = 12;
    localparam int LVL_W       = 4;
    localparam int ROW_AW      = 11;
    localparam int ROW_DEPTH   = 2048;
    localparam int NODE_DEPTH  = 4096;
    localparam logic [11:0] TOTAL_UNITS = 12'd2048;
    localparam logic [3:0]  LAST_LEVEL  = 4'(TREE_LEVELS - 1);

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOMEM    = 2'd1;
    localparam logic [1:0] ST_FRAG     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;

    typedef logic [3:0] t_op;

    // Datapath commands
    localparam t_op OP_NONE      = 4'd0;
    localparam t_op OP_CLEAR     = 4'd1;
    localparam t_op OP_LOAD      = 4'd2;
    localparam t_op OP_RD_ROW    = 4'd3;
    localparam t_op OP_RD_UP     = 4'd4;
    localparam t_op OP_SET_SPLIT = 4'd5;
    localparam t_op OP_CLR_KIDS  = 4'd6;
    localparam t_op OP_ALLOC     = 4'd7;
    localparam t_op OP_FREE      = 4'd8;
    localparam t_op OP_MERGE_CLR = 4'd9;
    localparam t_op OP_DOWN      = 4'd10;
    localparam t_op OP_DOWN_R    = 4'd11;
    localparam t_op OP_SIB       = 4'd12;
    localparam t_op OP_UP        = 4'd13;
    localparam t_op OP_FINISH    = 4'd14;

    typedef struct packed {
        t_op        op;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic own_split;
        logic own_alloc;
        logic row_zero;
        logic is_root;
        logic is_left;
        logic at_bottom;
        logic req_gt_size;
        logic req_gt_half;
        logic used_match;
        logic found;
        logic over_total;
        logic clr_done;
        logic act;
    } t_stat;

endpackage

/* rtl/bba_dpath.sv */
module bba_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load_action,
    input  logic [11:0]        i_load_size,
    input  bba_pkg::t_cmd      i_cmd,
    output bba_pkg::t_stat     o_stat,
    output logic [1:0]         o_status,
    output logic [10:0]        o_block_offset,
    output logic [11:0]        o_block_size,
    output logic [11:0]        o_free_total
);
    import bba_pkg::*;

    // Row p holds {split, alloc} of nodes 2p (upper half) and 2p+1 (lower half)
    logic [3:0]  flag_mem [ROW_DEPTH];
    logic [11:0] used_mem [NODE_DEPTH];

    logic [3:0]        r_row;
    logic [11:0]       r_used;
    logic [NODE_W-1:0] r_node;
    logic [LVL_W-1:0]  r_lvl;
    logic [11:0]       r_req;
    logic              r_act;
    logic              r_found;
    logic [10:0]       r_hit_off;
    logic [11:0]       r_hit_size;
    logic [11:0]       r_total;
    logic [11:0]       r_clr_cnt;
    logic              r_root_split;
    logic              r_root_alloc;

    logic              w_is_root;
    logic              w_own_split;
    logic              w_own_alloc;
    logic [11:0]       w_size;
    logic [11:0]       w_half;
    logic [NODE_W-1:0] w_shifted;
    logic [12:0]       w_sum;
    logic [11:0]       n_total;
    logic              w_wr_en;
    logic [ROW_AW-1:0] w_wr_addr;
    logic [3:0]        w_wr_data;
    logic              w_rd_en;
    logic [ROW_AW-1:0] w_rd_addr;

    // Decode the current node from the row last read
    assign w_is_root   = (r_node == NODE_W'(1));
    assign w_own_split = w_is_root ? r_root_split : (r_node[0] ? r_row[1] : r_row[3]);
    assign w_own_alloc = w_is_root ? r_root_alloc : (r_node[0] ? r_row[0] : r_row[2]);
    assign w_size      = TOTAL_UNITS >> r_lvl;
    assign w_half      = w_size >> 1;
    assign w_shifted   = r_node << (LAST_LEVEL - r_lvl);

    assign o_stat.own_split   = w_own_split;
    assign o_stat.own_alloc   = w_own_alloc;
    assign o_stat.row_zero    = (r_row == 4'd0);
    assign o_stat.is_root     = w_is_root;
    assign o_stat.is_left     = ~r_node[0];
    assign o_stat.at_bottom   = (r_lvl == LAST_LEVEL);
    assign o_stat.req_gt_size = (r_req > w_size);
    assign o_stat.req_gt_half = (r_req > w_half);
    assign o_stat.used_match  = (r_used == r_req);
    assign o_stat.found       = r_found;
    assign o_stat.over_total  = (r_req > r_total);
    assign o_stat.clr_done    = r_clr_cnt[11];
    assign o_stat.act         = r_act;

    // Total after a successful request, saturating on release
    always_comb begin
        w_sum   = {1'b0, r_total} + {1'b0, r_req};
        n_total = r_total;
        if (i_cmd.status == ST_OK) begin
            if (r_act == ACT_ALLOC) begin
                n_total = r_total - r_req;
            end else if (w_sum > {1'b0, TOTAL_UNITS}) begin
                n_total = TOTAL_UNITS;
            end else begin
                n_total = w_sum[11:0];
            end
        end
    end

    // Flag memory port control
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_node[11:1];
        w_wr_data = 4'd0;
        w_rd_addr = r_node[11:1];
        w_rd_en   = (i_cmd.op == OP_RD_ROW) || (i_cmd.op == OP_RD_UP);
        unique case (i_cmd.op)
            OP_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_cnt[10:0];
            end
            OP_RD_UP: begin
                w_rd_addr = {1'b0, r_node[11:2]};
            end
            OP_SET_SPLIT: begin
                w_wr_en   = ~w_is_root;
                w_wr_data = r_node[0] ? (r_row | 4'b0010) : (r_row | 4'b1000);
            end
            OP_CLR_KIDS: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_node[10:0];
            end
            OP_ALLOC: begin
                w_wr_en   = ~w_is_root;
                w_wr_data = r_node[0] ? (r_row | 4'b0001) : (r_row | 4'b0100);
            end
            OP_FREE: begin
                w_wr_en   = ~w_is_root;
                w_wr_data = r_node[0] ? (r_row & 4'b1110) : (r_row & 4'b1011);
            end
            OP_MERGE_CLR: begin
                w_wr_en   = (r_node[11:1] != 11'd1);
                w_wr_addr = {1'b0, r_node[11:2]};
                w_wr_data = r_node[1] ? (r_row & 4'b1101) : (r_row & 4'b0111);
            end
            default: ;
        endcase
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            flag_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_row <= flag_mem[w_rd_addr];
        end
        if (i_cmd.op == OP_ALLOC) begin
            used_mem[r_node] <= r_req;
        end
        if (i_cmd.op == OP_RD_ROW) begin
            r_used <= used_mem[r_node];
        end
    end

    // Control state: clear pass, root flags, running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt    <= 12'd0;
            r_root_split <= 1'b0;
            r_root_alloc <= 1'b0;
            r_total      <= TOTAL_UNITS;
        end else begin
            if (i_cmd.op == OP_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 12'd1;
            end
            if (w_is_root) begin
                if (i_cmd.op == OP_SET_SPLIT) r_root_split <= 1'b1;
                if (i_cmd.op == OP_ALLOC)     r_root_alloc <= 1'b1;
                if (i_cmd.op == OP_FREE)      r_root_alloc <= 1'b0;
            end
            if (i_cmd.op == OP_MERGE_CLR && r_node[11:1] == 11'd1) begin
                r_root_split <= 1'b0;
            end
            if (i_cmd.op == OP_FINISH) begin
                r_total <= n_total;
            end
        end
    end

    // Walk position, request and result registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_req      <= (i_load_size == 12'd0) ? 12'd1 : i_load_size;
                r_act      <= i_load_action;
                r_node     <= NODE_W'(1);
                r_lvl      <= '0;
                r_found    <= 1'b0;
                r_hit_off  <= 11'd0;
                r_hit_size <= 12'd0;
            end
            OP_ALLOC, OP_FREE: begin
                r_found    <= 1'b1;
                r_hit_off  <= w_shifted[10:0];
                r_hit_size <= w_size;
            end
            OP_DOWN: begin
                r_node <= {r_node[NODE_W-2:0], 1'b0};
                r_lvl  <= r_lvl + LVL_W'(1);
            end
            OP_DOWN_R: begin
                r_node <= {r_node[NODE_W-2:0], 1'b1};
                r_lvl  <= r_lvl + LVL_W'(1);
            end
            OP_SIB: begin
                r_node <= r_node + NODE_W'(1);
            end
            OP_UP: begin
                r_node <= r_node >> 1;
                r_lvl  <= r_lvl - LVL_W'(1);
            end
            OP_FINISH: begin
                o_status       <= i_cmd.status;
                o_block_offset <= (i_cmd.status == ST_OK) ? r_hit_off : 11'd0;
                o_block_size   <= (i_cmd.status == ST_OK) ? r_hit_size : 12'd0;
                o_free_total   <= n_total;
            end
            default: ;
        endcase
    end

endmodule

/* rtl/bba_ctrl.sv */
module bba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  bba_pkg::t_stat i_stat,
    output bba_pkg::t_cmd  o_cmd
);
    import bba_pkg::*;

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_CHK    = 5'd2;
    localparam logic [4:0] G_RD     = 5'd3;
    localparam logic [4:0] G_EVAL   = 5'd4;
    localparam logic [4:0] G_SPLIT  = 5'd5;
    localparam logic [4:0] G_DOWN   = 5'd6;
    localparam logic [4:0] G_FAIL   = 5'd7;
    localparam logic [4:0] R_RD     = 5'd8;
    localparam logic [4:0] R_ENTER  = 5'd9;
    localparam logic [4:0] R_LEAF   = 5'd10;
    localparam logic [4:0] R_MERGE  = 5'd11;
    localparam logic [4:0] R_MCHK   = 5'd12;
    localparam logic [4:0] R_MWR    = 5'd13;
    localparam logic [4:0] R_RET    = 5'd14;
    localparam logic [4:0] R_UPL_RD = 5'd15;
    localparam logic [4:0] R_UPL    = 5'd16;
    localparam logic [4:0] R_UPR_RD = 5'd17;
    localparam logic [4:0] R_UPR    = 5'd18;
    localparam logic [4:0] S_DONE   = 5'd19;

    logic [4:0] r_state, n_state;
    logic [1:0] r_res, n_res;
    logic       r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Sequence the tree walk
    always_comb begin
        n_state      = r_state;
        n_res        = r_res;
        n_out_valid  = r_out_valid & ~i_out_ready;
        o_cmd.op     = OP_NONE;
        o_cmd.status = r_res;
        unique case (r_state)
            S_CLR: begin
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.op = OP_CLEAR;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.act != ACT_ALLOC) begin
                    n_state = R_RD;
                end else if (i_stat.over_total) begin
                    n_res   = ST_NOMEM;
                    n_state = S_DONE;
                end else begin
                    n_state = G_RD;
                end
            end
            G_RD: begin
                o_cmd.op = OP_RD_ROW;
                n_state  = G_EVAL;
            end
            G_EVAL: begin
                if (i_stat.req_gt_size) begin
                    n_state = G_FAIL;
                end else if (i_stat.req_gt_half) begin
                    if (!i_stat.own_split && !i_stat.own_alloc) begin
                        o_cmd.op = OP_ALLOC;
                        n_res    = ST_OK;
                        n_state  = S_DONE;
                    end else begin
                        n_state = G_FAIL;
                    end
                end else if (i_stat.own_alloc) begin
                    n_state = G_FAIL;
                end else if (i_stat.own_split) begin
                    o_cmd.op = OP_DOWN;
                    n_state  = G_RD;
                end else if (i_stat.at_bottom) begin
                    n_state = G_FAIL;
                end else begin
                    o_cmd.op = OP_SET_SPLIT;
                    n_state  = G_SPLIT;
                end
            end
            G_SPLIT: begin
                o_cmd.op = OP_CLR_KIDS;
                n_state  = G_DOWN;
            end
            G_DOWN: begin
                o_cmd.op = OP_DOWN;
                n_state  = G_RD;
            end
            G_FAIL: begin
                if (i_stat.is_root) begin
                    n_res   = ST_FRAG;
                    n_state = S_DONE;
                end else if (i_stat.is_left) begin
                    o_cmd.op = OP_SIB;
                    n_state  = G_RD;
                end else begin
                    o_cmd.op = OP_UP;
                end
            end
            R_RD: begin
                o_cmd.op = OP_RD_ROW;
                n_state  = R_ENTER;
            end
            R_ENTER: begin
                if (i_stat.own_split) begin
                    o_cmd.op = OP_DOWN;
                    n_state  = R_RD;
                end else begin
                    n_state = R_LEAF;
                end
            end
            R_LEAF: begin
                if (!i_stat.own_alloc) begin
                    n_state = R_MERGE;
                end else if (!i_stat.found && i_stat.used_match) begin
                    o_cmd.op = OP_FREE;
                    n_state  = R_MERGE;
                end else begin
                    n_state = R_RET;
                end
            end
            R_MERGE: begin
                if (i_stat.is_root) begin
                    n_state = R_RET;
                end else begin
                    o_cmd.op = OP_RD_ROW;
                    n_state  = R_MCHK;
                end
            end
            R_MCHK: begin
                if (i_stat.row_zero) begin
                    o_cmd.op = OP_RD_UP;
                    n_state  = R_MWR;
                end else begin
                    n_state = R_RET;
                end
            end
            R_MWR: begin
                o_cmd.op = OP_MERGE_CLR;
                n_state  = R_RET;
            end
            R_RET: begin
                if (i_stat.is_root) begin
                    n_res   = i_stat.found ? ST_OK : ST_NOTFOUND;
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_UP;
                    n_state  = i_stat.is_left ? R_UPL_RD : R_UPR_RD;
                end
            end
            R_UPL_RD: begin
                o_cmd.op = OP_RD_ROW;
                n_state  = R_UPL;
            end
            R_UPL: begin
                if (i_stat.own_split) begin
                    o_cmd.op = OP_DOWN_R;
                    n_state  = R_RD;
                end else begin
                    n_state = R_LEAF;
                end
            end
            R_UPR_RD: begin
                o_cmd.op = OP_RD_ROW;
                n_state  = R_UPR;
            end
            R_UPR: begin
                n_state = i_stat.own_split ? R_RET : R_LEAF;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_res       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/buddy_block_allocator_unit.sv */
// Buddy allocator over 2048 units held as a binary tree of 4095 nodes. An
// allocate request (action 0) searches left-first from the root and grants
// the first free unsplit block whose half is smaller than the size, splitting
// on the way down; a release (action 1) walks the tree in postorder, frees
// the first allocated block that recorded the same size and merges free
// buddies upward. A size of 0 counts as 1. After reset the flag memory is
// cleared row by row, during which no request is taken. One request is
// handled at a time: the walk visits tree nodes one after another, so a
// release or a heavily fragmented search can touch the whole tree, while an
// allocation larger than the free total is refused without a walk.
module buddy_block_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [11:0] i_request_size,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [10:0] o_block_offset,
    output logic [11:0] o_block_size,
    output logic [11:0] o_free_total
);
    import bba_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Walk sequencer
    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Tree flags, sizes and result registers
    bba_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load_action  (i_action),
        .i_load_size    (i_request_size),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_status       (o_status),
        .o_block_offset (o_block_offset),
        .o_block_size   (o_block_size),
        .o_free_total   (o_free_total)
    );

endmodule

/* rtl/bba_checker.sv */
`include "buddy_block_allocator_unit_defines.svh"

module bba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [10:0] o_block_offset,
    input logic [11:0] o_block_size,
    input logic [11:0] o_free_total
);
    import bba_pkg::*;

    // One request at a time: ready drops right after a request is taken
    `BBA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "request taken while busy")

    // A granted or freed block has a size
    `BBA_ASSERT_NOW(a_ok_has_size, i_clk, i_rst_n, o_out_valid && o_status == ST_OK, o_block_size != 12'd0, "ok result without block")

    // Failures report no block
    `BBA_ASSERT_NOW(a_fail_no_block, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, o_block_size == 12'd0 && o_block_offset == 11'd0, "failed result names a block")

    // Unallocated total never exceeds the pool
    `BBA_ASSERT_NOW(a_total_bound, i_clk, i_rst_n, o_out_valid, o_free_total <= TOTAL_UNITS, "free total above pool size")

endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

import bba_pkg::*;

typedef struct {
    logic [1:0]  status;
    logic [10:0] offset;
    logic [11:0] size;
    logic [11:0] free_total;
} t_grant_result;

class buddy_scoreboard;
    bit          split_q[4096];
    bit          alloc_q[4096];
    int unsigned used_q[4096];
    int unsigned units_left;
    int unsigned hit_off;
    int unsigned hit_sz;
    bit          hit_done;
    t_grant_result pending_q[$];
    int          err_count;
    int          n_alloc_ok;
    int          n_free_ok;
    int          n_fail;

    function new();
        units_left = TOTAL_UNITS;
    endfunction

    // Descend left-first, splitting free blocks that are large enough
    function bit try_grant(int unsigned node, int unsigned lvl, int unsigned off,
                           int unsigned sz, int unsigned req);
        if (req > sz) return 0;
        if (req > sz / 2) begin
            if (!split_q[node] && !alloc_q[node]) begin
                alloc_q[node] = 1;
                used_q[node]  = req;
                hit_off = off;
                hit_sz  = sz;
                return 1;
            end
            return 0;
        end
        if (alloc_q[node]) return 0;
        if (!split_q[node]) begin
            if (lvl + 1 >= TREE_LEVELS || sz < 2) return 0;
            split_q[node]         = 1;
            split_q[2*node]       = 0;
            split_q[2*node + 1]   = 0;
            alloc_q[2*node]       = 0;
            alloc_q[2*node + 1]   = 0;
            used_q[2*node]        = 0;
            used_q[2*node + 1]    = 0;
        end
        if (try_grant(2*node, lvl + 1, off, sz / 2, req)) return 1;
        return try_grant(2*node + 1, lvl + 1, off + sz / 2, sz / 2, req);
    endfunction

    // Clear the parent split when both buddies are free leaves
    function void merge_up(int unsigned node);
        int unsigned l;
        if (node <= 1) return;
        l = 2 * (node >> 1);
        if (!alloc_q[l] && !alloc_q[l+1] && !split_q[l] && !split_q[l+1])
            split_q[node >> 1] = 0;
    endfunction

    // Postorder walk: free the first leaf that recorded this size
    function void free_walk(int unsigned node, int unsigned off, int unsigned sz,
                            int unsigned req);
        if (split_q[node]) begin
            free_walk(2*node, off, sz / 2, req);
            if (split_q[node]) free_walk(2*node + 1, off + sz / 2, sz / 2, req);
        end
        if (split_q[node]) return;
        if (!alloc_q[node]) begin
            merge_up(node);
        end else if (!hit_done && used_q[node] == req) begin
            alloc_q[node] = 0;
            used_q[node]  = 0;
            hit_done = 1;
            hit_off  = off;
            hit_sz   = sz;
            merge_up(node);
        end
    endfunction

    // Note an accepted request; return the predicted status
    function logic [1:0] note_request(logic act, logic [11:0] req_in);
        int unsigned   req;
        t_grant_result r;
        req = (req_in == 0) ? 1 : req_in;
        hit_off = 0;
        hit_sz = 0;
        hit_done = 0;
        if (act == ACT_ALLOC) begin
            if (req > units_left) begin
                r.status = ST_NOMEM;
            end else if (try_grant(1, 0, 0, TOTAL_UNITS, req)) begin
                r.status = ST_OK;
                units_left -= req;
            end else begin
                r.status = ST_FRAG;
                hit_off = 0;
                hit_sz = 0;
            end
        end else begin
            free_walk(1, 0, TOTAL_UNITS, req);
            if (hit_done) begin
                r.status = ST_OK;
                units_left += req;
                if (units_left > TOTAL_UNITS) units_left = TOTAL_UNITS;
            end else begin
                r.status = ST_NOTFOUND;
                hit_off = 0;
                hit_sz = 0;
            end
        end
        r.offset     = hit_off[10:0];
        r.size       = hit_sz[11:0];
        r.free_total = units_left[11:0];
        if (r.status != ST_OK) n_fail++;
        else if (act == ACT_ALLOC) n_alloc_ok++;
        else n_free_ok++;
        pending_q.push_back(r);
        return r.status;
    endfunction

    function void report_mismatch(string what, int got, int want);
        $display("%0t mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(logic [1:0] st, logic [10:0] off, logic [11:0] sz,
                               logic [11:0] ft);
        t_grant_result e;
        if (pending_q.size() == 0) begin
            report_mismatch("unexpected result status", st, -1);
            return;
        end
        e = pending_q.pop_front();
        if (st !== e.status) report_mismatch("status", st, e.status);
        if (off !== e.offset) report_mismatch("block_offset", off, e.offset);
        if (sz !== e.size) report_mismatch("block_size", sz, e.size);
        if (ft !== e.free_total) report_mismatch("free_total", ft, e.free_total);
    endfunction
endclass

module tb_top;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic        i_action = 0;
    logic [11:0] i_request_size = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic [1:0]  o_status;
    logic [10:0] o_block_offset;
    logic [11:0] o_block_size;
    logic [11:0] o_free_total;

    buddy_scoreboard board = new();
    bit          no_stall = 0;
    logic [11:0] live_sizes[$];

    buddy_block_allocator_unit dut (.*);

    always #6 i_clk = ~i_clk;

    // Fail the run if it hangs
    initial begin
        #200_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Drain results with random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_status, o_block_offset, o_block_size, o_free_total);
        i_out_ready <= no_stall || ($urandom_range(99) >= 15);
    end

    // Present one request and hold it until taken
    task automatic send_request(logic act, logic [11:0] req);
        logic [1:0] st;
        if (!no_stall && $urandom_range(99) < 15) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid     <= 1;
        i_action       <= act;
        i_request_size <= req;
        do @(posedge i_clk); while (!o_in_ready);
        st = board.note_request(act, req);
        if (act == ACT_ALLOC && st == ST_OK) live_sizes.push_back(req == 0 ? 12'd1 : req);
    endtask

    function automatic logic [11:0] pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return 12'($urandom_range(0, 64));
        if (r < 90) return 12'($urandom_range(65, 512));
        return 12'($urandom_range(513, 2048));
    endfunction

    initial begin
        int unsigned k;
        logic [11:0] sz;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: whole tree, full pool, root release, missing size, zero size
        send_request(ACT_ALLOC, 12'd2048);
        send_request(ACT_ALLOC, 12'd1);
        send_request(~ACT_ALLOC, 12'd2048);
        send_request(~ACT_ALLOC, 12'd5);
        send_request(ACT_ALLOC, 12'd0);
        send_request(~ACT_ALLOC, 12'd0);
        // Fragmentation: left half split, right half taken
        send_request(ACT_ALLOC, 12'd1);
        send_request(ACT_ALLOC, 12'd1024);
        send_request(ACT_ALLOC, 12'd1024);
        send_request(ACT_ALLOC, 12'd1023);
        send_request(ACT_ALLOC, 12'd1);
        send_request(ACT_ALLOC, 12'd1);
        // First match only: three blocks recorded with size 1
        send_request(~ACT_ALLOC, 12'd1);
        send_request(~ACT_ALLOC, 12'd1024);
        send_request(ACT_ALLOC, 12'd1023);
        send_request(ACT_ALLOC, 12'hFFF & 12'd1365);
        send_request(~ACT_ALLOC, 12'd1023);
        send_request(~ACT_ALLOC, 12'd1);
        send_request(~ACT_ALLOC, 12'd1);
        send_request(~ACT_ALLOC, 12'd1);
        send_request(ACT_ALLOC, 12'd2048);
        send_request(~ACT_ALLOC, 12'd2048);
        live_sizes.delete();

        // Hold off until every result is back
        i_in_valid <= 0;
        while (board.pending_q.size() != 0) @(posedge i_clk);

        // Random mix of allocations and releases, mostly of live sizes
        for (k = 0; k < 118; k++) begin
            no_stall = (k >= 60 && k < 100);
            if (k == 30) begin
                i_in_valid <= 0;
                while (board.pending_q.size() != 0) @(posedge i_clk);
            end
            if (live_sizes.size() > 0 && $urandom_range(99) < 45) begin
                if ($urandom_range(99) < 85) begin
                    int unsigned idx;
                    idx = $urandom_range(live_sizes.size() - 1);
                    sz = live_sizes[idx];
                    live_sizes.delete(idx);
                end else begin
                    sz = pick_size();
                end
                send_request(~ACT_ALLOC, sz);
            end else begin
                send_request(ACT_ALLOC, pick_size());
            end
        end
        i_in_valid <= 0;
        no_stall = 0;

        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("covered %0d grants, %0d releases, %0d refused requests",
                 board.n_alloc_ok, board.n_free_ok, board.n_fail);
        $display("with random idling on both sides and a drained pause");
        if (board.err_count == 0 && board.pending_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
